// ===== hdl/ecbp_pkg.sv =====
// Shared constants and types for the entropy code bit packer.
package ecbp_pkg;

    localparam int VAL_W  = 16;
    localparam int LEN_W  = 5;
    localparam int PEND_W = 7;
    localparam int CNT_W  = 3;
    localparam int NB_W   = 3;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] ALL_ONES_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;

    // Per-item control that travels with the packed bytes through the queue.
    typedef struct packed {
        logic [NB_W-1:0] nbytes;
        logic            flush;
    } item_ctl_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== hdl/ecbp_front.sv =====
// Front part: accepts codes, merges them with pending bits and forms whole bytes.
module ecbp_front #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [ecbp_pkg::VAL_W-1:0]             code_value,
    input  logic [ecbp_pkg::LEN_W-1:0]             code_length,
    input  logic                                   flush,
    input  ecbp_pkg::q_stat_t                      q_stat,
    output logic                                   push,
    output ecbp_pkg::item_ctl_t                    push_ctl,
    output logic [((ecbp_pkg::PEND_W + MAX_CODE_BITS + 7) / 8) * 8 - 1:0] push_bytes
);

    localparam int ACC_W = ecbp_pkg::PEND_W + MAX_CODE_BITS;
    localparam int BW    = ((ACC_W + 7) / 8) * 8;
    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam int SH_W  = $clog2(BW + 1);

    logic [ecbp_pkg::PEND_W-1:0] bits_reg;
    logic [ecbp_pkg::PEND_W-1:0] bits_next;
    logic [ecbp_pkg::CNT_W-1:0]  cnt_reg;
    logic [ecbp_pkg::CNT_W-1:0]  cnt_next;

    logic                        accept;
    logic [TOT_W-1:0]            len_sat;
    logic [TOT_W-1:0]            total;
    logic [ACC_W-1:0]            combined;
    logic [BW-1:0]               aligned;
    logic [BW-1:0]               pad;
    logic [ecbp_pkg::CNT_W-1:0]  rem;
    logic [ecbp_pkg::NB_W-1:0]   nb;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (int'(code_length) > MAX_CODE_BITS)
        begin
            len_sat = TOT_W'(MAX_CODE_BITS);
        end
        else
        begin
            len_sat = TOT_W'(code_length);
        end
        total    = len_sat + TOT_W'(cnt_reg);
        combined = (ACC_W'(bits_reg) << len_sat)
                 | (ACC_W'(code_value) & ~({ACC_W{1'b1}} << len_sat));
        // Left-align the stream so that byte 0 sits in the top eight bits.
        aligned  = BW'(combined) << (SH_W'(BW) - SH_W'(total));
        pad      = flush ? ({BW{1'b1}} >> total) : '0;
        rem      = total[ecbp_pkg::CNT_W-1:0];
        if (flush && (rem != '0))
        begin
            nb = ecbp_pkg::NB_W'(total >> 3) + 1'b1;
        end
        else
        begin
            nb = ecbp_pkg::NB_W'(total >> 3);
        end
        bits_next = ecbp_pkg::PEND_W'(combined) & ~({ecbp_pkg::PEND_W{1'b1}} << rem);
        cnt_next  = rem;
        if (flush)
        begin
            bits_next = '0;
            cnt_next  = '0;
        end
    end

    assign push            = accept && (nb != '0);
    assign push_ctl.nbytes = nb;
    assign push_ctl.flush  = flush;
    assign push_bytes      = aligned | pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Bits above the pending count must stay clear, or they would leak into later bytes.
    a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (bits_reg & ({ecbp_pkg::PEND_W{1'b1}} << cnt_reg)) == '0)
        else $error("pending bits set above pending count");

endmodule

// ===== hdl/ecbp_queue.sv =====
// Short queue of packed items between the front and back parts.
module ecbp_queue #(
    parameter int DATA_W = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output ecbp_pkg::q_stat_t stat
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;

    assign stat.full  = (count_reg == (PTR_W + 1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/ecbp_back.sv =====
// Back part: sends the bytes of each item one per cycle while out_stall is low and inserts stuffed zeros.
module ecbp_back #(
    parameter int BW = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ecbp_pkg::item_ctl_t              head_ctl,
    input  logic [BW-1:0]                    head_bytes,
    input  ecbp_pkg::q_stat_t                q_stat,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ecbp_pkg::BYTE_W-1:0]      out_byte,
    output logic                             is_stuffed,
    output logic                             last
);

    localparam int MAX_BYTES = BW / 8;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [ecbp_pkg::BYTE_W-1:0]    out_byte_reg;
    logic [ecbp_pkg::BYTE_W-1:0]    out_byte_next;
    logic                           stuffed_reg;
    logic                           stuffed_next;
    logic                           last_reg;
    logic                           last_next;
    logic [ecbp_pkg::NB_W-1:0]      idx_reg;
    logic [ecbp_pkg::NB_W-1:0]      idx_next;
    logic                           stuff_reg;
    logic                           stuff_next;

    logic                           load;
    logic                           go;
    logic                           final_byte;
    logic [ecbp_pkg::BYTE_W-1:0]    sel_byte;

    assign load = !out_valid_reg || !out_stall;
    assign go   = load && !q_stat.empty;

    always_comb
    begin
        sel_byte = '0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (idx_reg == ecbp_pkg::NB_W'(i))
            begin
                sel_byte = head_bytes[BW - 1 - 8 * i -: 8];
            end
        end
    end

    assign final_byte = (idx_reg == head_ctl.nbytes - 1'b1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        stuffed_next   = stuffed_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        stuff_next     = stuff_reg;
        pop            = 1'b0;
        if (go)
        begin
            out_valid_next = 1'b1;
            if (stuff_reg)
            begin
                out_byte_next = ecbp_pkg::STUFF_BYTE;
                stuffed_next  = 1'b1;
                last_next     = head_ctl.flush && (idx_reg == head_ctl.nbytes);
                stuff_next    = 1'b0;
                if (idx_reg == head_ctl.nbytes)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
            end
            else
            begin
                out_byte_next = sel_byte;
                stuffed_next  = 1'b0;
                if (sel_byte == ecbp_pkg::ALL_ONES_BYTE)
                begin
                    last_next  = 1'b0;
                    stuff_next = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
                else
                begin
                    last_next = head_ctl.flush && final_byte;
                    if (final_byte)
                    begin
                        pop      = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            stuff_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            stuff_reg     <= stuff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        stuffed_reg  <= stuffed_next;
        last_reg     <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_stuffed = stuffed_reg;
    assign last       = last_reg;

    a_stuff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_stuffed |-> out_byte == ecbp_pkg::STUFF_BYTE)
        else $error("stuffed byte is not zero");

    a_stuff_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !is_stuffed && (out_byte == ecbp_pkg::ALL_ONES_BYTE)
        |=> out_valid && is_stuffed)
        else $error("0xFF transfer not followed by a stuffed zero");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

endmodule

// ===== hdl/entropy_code_bit_packer_with_stuffing.sv =====
// Top level of the entropy code bit packer with 0xFF byte stuffing.
//
// Input channel: in_valid/in_stall carry one code per transfer (code_value,
// code_length, flush). Code bits are appended most significant first to a
// small accumulator; code lengths above MAX_CODE_BITS are clipped to it.
// Output channel: out_valid/out_stall carry one stream byte per transfer,
// with is_stuffed marking the 0x00 inserted after each 0xFF and last marking
// the final byte that a flush item produces.
// The first byte of a code passes through the queue and then the output
// register before it reaches the output. The output register sends one byte
// per cycle while out_stall is low; a code makes 0 to 6 bytes with the
// default MAX_CODE_BITS. A four-entry queue between the front and back
// parts lets new codes arrive while earlier bytes still drain.
// Reset clears the pending bits, the queue and the output valid flag.
// When the receiver stalls, the output byte holds; once the queue fills,
// in_stall rises and the sender waits.
module entropy_code_bit_packer_with_stuffing #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ecbp_pkg::VAL_W-1:0]    code_value,
    input  logic [ecbp_pkg::LEN_W-1:0]    code_length,
    input  logic                          flush,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ecbp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          is_stuffed,
    output logic                          last
);

    // Width of the byte window that one code can fill, rounded to whole bytes.
    localparam int BW     = ((ecbp_pkg::PEND_W + MAX_CODE_BITS + 7) / 8) * 8;
    localparam int DATA_W = BW + $bits(ecbp_pkg::item_ctl_t);

    ecbp_pkg::q_stat_t   q_stat;
    ecbp_pkg::item_ctl_t push_ctl;
    ecbp_pkg::item_ctl_t head_ctl;
    logic [BW-1:0]       push_bytes;
    logic [BW-1:0]       head_bytes;
    logic                push;
    logic                pop;
    logic [DATA_W-1:0]   head_data;

    // The front classifies each transfer: how many whole bytes it completes
    // and whether it ends the scan. Codes that complete nothing only update
    // the pending bits and never enter the queue.
    ecbp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_value  (code_value),
        .code_length (code_length),
        .flush       (flush),
        .q_stat      (q_stat),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_bytes  (push_bytes)
    );

    ecbp_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_bytes}),
        .pop       (pop),
        .pop_data  (head_data),
        .stat      (q_stat)
    );

    assign head_ctl   = head_data[DATA_W-1:BW];
    assign head_bytes = head_data[BW-1:0];

    // The back walks the bytes of the head item and places a stuffed zero
    // right after every 0xFF before it moves on.
    ecbp_back #(
        .BW (BW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_ctl   (head_ctl),
        .head_bytes (head_bytes),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .is_stuffed (is_stuffed),
        .last       (last)
    );

endmodule
